FILE: rtl/dhte_pkg.sv
// Package: item types, controller commands, status group and codes for the hash table engine.
`timescale 1ns / 1ps

package dhte_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_REPLACE = 3'd1;
    localparam logic [2:0] MODE_REMOVE  = 3'd2;
    localparam logic [2:0] MODE_FIND    = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_KEY  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Slot key marks and hash shifts
    localparam logic [63:0] EMPTY_KEY = 64'h0000_0000_0000_0000;
    localparam logic [63:0] TOMB_KEY  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int unsigned H1_SHIFT  = 13;
    localparam int unsigned H2_SHIFT  = 17;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] key;
        logic [63:0] data_in;
    } t_in_item;

    typedef struct packed {
        logic [63:0] result_value;
        logic        hit;
        logic [1:0]  status;
        logic [10:0] entries_used;
    } t_out_item;

    // Datapath commands issued by the controller, one per cycle
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_BAD,
        CMD_CLR0,
        CMD_CLR1,
        CMD_LK_INIT,
        CMD_LK_RD,
        CMD_HIT,
        CMD_MISS,
        CMD_LK_NEXT,
        CMD_LK_END,
        CMD_GROW,
        CMD_SHRINK,
        CMD_R_CLR,
        CMD_W_RD,
        CMD_W_LIVE,
        CMD_W_NEXT,
        CMD_P_RD,
        CMD_P_PUT,
        CMD_P_NEXT,
        CMD_R_FIN,
        CMD_OUT
    } t_cmd;

    // Datapath status seen by the controller
    typedef struct packed {
        logic op_ins;      // insert or replace
        logic op_rem;
        logic op_find;
        logic op_clr;
        logic bad_key;
        logic grow_ok;
        logic shrink_ok;
        logic key_match;   // read slot holds the item key
        logic key_empty;   // read slot is empty
        logic key_live;    // read slot holds a live key
        logic probe_last;  // lookup probe count reaches table size
        logic put_last;    // rehash probe count reaches new size
        logic clr_last;    // last slot of new bank cleared
        logic walk_last;   // last slot of old bank visited
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

FILE: rtl/dhte_dp.sv
// Datapath: slot memories, table counters, probe registers and output register.
`timescale 1ns / 1ps

module dhte_dp #(
    parameter int CAPACITY = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dhte_pkg::t_cmd       i_cmd,
    input  dhte_pkg::t_in_item   i_in_item,
    input  logic                 i_out_stall,
    output dhte_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output dhte_pkg::t_out_item  o_out_item
);
    import dhte_pkg::*;

    localparam int IW     = $clog2(CAPACITY);
    localparam int CW     = IW + 1;
    localparam int AW     = IW + 1;
    localparam int NSLOTS = 2 * CAPACITY;
    localparam logic [CW:0] CAP_W = (CW + 1)'(CAPACITY);

    // Slot memories, two banks of CAPACITY slots
    logic [63:0] r_keys [NSLOTS];
    logic [63:0] r_vals [NSLOTS];
    logic [63:0] r_krd;
    logic [63:0] r_vrd;

    logic [2:0]    r_mode;
    logic [63:0]   r_key;
    logic [63:0]   r_data;
    logic [CW-1:0] r_size;
    logic [CW-1:0] r_live;
    logic [CW-1:0] r_free;
    logic          r_bank;
    logic [IW-1:0] r_q;
    logic [IW-1:0] r_x;
    logic [CW-1:0] r_n;
    logic          r_ffound;
    logic [IW-1:0] r_fslot;
    logic [IW-1:0] r_i;
    logic [CW-1:0] r_m;
    logic [63:0]   r_k2;
    logic [63:0]   r_v2;
    logic [63:0]   r_val;
    logic          r_hit;
    logic [1:0]    r_status;
    t_out_item     r_out;
    logic          r_out_valid;

    logic          wk_en;
    logic          wv_en;
    logic [AW-1:0] w_addr;
    logic [63:0]   wk;
    logic [63:0]   wv;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] size_m1;
    logic [CW-1:0] m_m1;
    logic [IW-1:0] size_mask;
    logic [IW-1:0] m_mask;
    logic [IW-1:0] hmask;
    logic [63:0]   hk;
    logic [63:0]   mix1;
    logic [63:0]   mix2;
    logic [IW-1:0] h1;
    logic [IW-1:0] h2;
    logic          op_ins;
    logic [31:0]   live32;

    // Table masks and hash of the key in hand
    assign size_m1   = r_size - 1'b1;
    assign m_m1      = r_m - 1'b1;
    assign size_mask = size_m1[IW-1:0];
    assign m_mask    = m_m1[IW-1:0];
    assign hk        = (i_cmd == CMD_W_LIVE) ? r_krd : r_key;
    assign hmask     = (i_cmd == CMD_W_LIVE) ? m_mask : size_mask;
    assign mix1      = hk ^ (hk >> H1_SHIFT);
    assign mix2      = (hk ^ (hk >> H2_SHIFT)) | 64'd1;
    assign h1        = mix1[IW-1:0] & hmask;
    assign h2        = mix2[IW-1:0] & hmask;
    assign op_ins    = (r_mode == MODE_INSERT) || (r_mode == MODE_REPLACE);
    assign live32    = 32'(r_live);

    // Status to the controller
    always_comb begin
        o_status.op_ins     = op_ins;
        o_status.op_rem     = (r_mode == MODE_REMOVE);
        o_status.op_find    = (r_mode == MODE_FIND);
        o_status.op_clr     = (r_mode == MODE_CLEAR);
        o_status.bad_key    = (r_mode <= MODE_FIND) && ((r_key == EMPTY_KEY) || (r_key == TOMB_KEY));
        o_status.grow_ok    = ({r_free, 1'b0} <= {1'b0, r_size}) && ({r_size, 1'b0} <= CAP_W);
        o_status.shrink_ok  = r_live < (r_size >> 2);
        o_status.key_match  = (r_krd == r_key);
        o_status.key_empty  = (r_krd == EMPTY_KEY);
        o_status.key_live   = (r_krd != EMPTY_KEY) && (r_krd != TOMB_KEY);
        o_status.probe_last = (r_n + 1'b1) == r_size;
        o_status.put_last   = (r_n + 1'b1) == r_m;
        o_status.clr_last   = {1'b0, r_i} == m_m1;
        o_status.walk_last  = {1'b0, r_i} == size_m1;
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    // Memory port selection for each command
    always_comb begin
        wk_en   = 1'b0;
        wv_en   = 1'b0;
        w_addr  = {r_bank, r_q};
        wk      = EMPTY_KEY;
        wv      = r_data;
        rd_en   = 1'b0;
        rd_addr = {r_bank, r_q};
        unique case (i_cmd)
            CMD_CLR0: begin
                wk_en  = 1'b1;
                w_addr = {r_bank, IW'(0)};
            end
            CMD_CLR1: begin
                wk_en  = 1'b1;
                w_addr = {r_bank, IW'(1)};
            end
            CMD_HIT: begin
                wv_en = (r_mode == MODE_REPLACE);
                wk_en = (r_mode == MODE_REMOVE);
                wk    = TOMB_KEY;
            end
            CMD_MISS: begin
                wk_en  = op_ins;
                wv_en  = op_ins;
                w_addr = {r_bank, (r_ffound ? r_fslot : r_q)};
                wk     = r_key;
            end
            CMD_LK_END: begin
                wk_en  = op_ins && r_ffound;
                wv_en  = op_ins && r_ffound;
                w_addr = {r_bank, r_fslot};
                wk     = r_key;
            end
            CMD_R_CLR: begin
                wk_en  = 1'b1;
                w_addr = {~r_bank, r_i};
            end
            CMD_P_PUT: begin
                wk_en  = 1'b1;
                wv_en  = 1'b1;
                w_addr = {~r_bank, r_q};
                wk     = r_k2;
                wv     = r_v2;
            end
            CMD_LK_RD: begin
                rd_en = 1'b1;
            end
            CMD_W_RD: begin
                rd_en   = 1'b1;
                rd_addr = {r_bank, r_i};
            end
            CMD_P_RD: begin
                rd_en   = 1'b1;
                rd_addr = {~r_bank, r_q};
            end
            default: begin
            end
        endcase
    end

    // Write and read the slot memories
    always_ff @(posedge i_clk) begin
        if (wk_en) begin
            r_keys[w_addr] <= wk;
        end
        if (wv_en) begin
            r_vals[w_addr] <= wv;
        end
        if (rd_en) begin
            r_krd <= r_keys[rd_addr];
            r_vrd <= r_vals[rd_addr];
        end
    end

    // Table counters and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CW'(2);
            r_live      <= '0;
            r_free      <= CW'(2);
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                CMD_CLR1: begin
                    r_size <= CW'(2);
                    r_live <= '0;
                    r_free <= CW'(2);
                end
                CMD_HIT: begin
                    if (r_mode == MODE_REMOVE && r_live != '0) begin
                        r_live <= r_live - 1'b1;
                    end
                end
                CMD_MISS: begin
                    if (op_ins) begin
                        r_live <= r_live + 1'b1;
                        if (!r_ffound && r_free != '0) begin
                            r_free <= r_free - 1'b1;
                        end
                    end
                end
                CMD_LK_END: begin
                    if (op_ins && r_ffound) begin
                        r_live <= r_live + 1'b1;
                    end
                end
                CMD_R_FIN: begin
                    r_bank <= ~r_bank;
                    r_size <= r_m;
                    r_free <= (r_m >= r_live) ? (r_m - r_live) : '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Probe, rehash and result registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_mode   <= i_in_item.mode;
                r_key    <= i_in_item.key;
                r_data   <= i_in_item.data_in;
                r_val    <= '0;
                r_hit    <= 1'b0;
                r_status <= ST_OK;
            end
            CMD_BAD: begin
                r_status <= ST_BAD_KEY;
            end
            CMD_LK_INIT: begin
                r_q      <= h1;
                r_x      <= h2;
                r_n      <= '0;
                r_ffound <= 1'b0;
            end
            CMD_HIT: begin
                r_hit <= 1'b1;
                r_val <= r_vrd;
            end
            CMD_LK_NEXT: begin
                if (r_krd == TOMB_KEY && !r_ffound) begin
                    r_ffound <= 1'b1;
                    r_fslot  <= r_q;
                end
                r_q <= (r_q + r_x) & size_mask;
                r_n <= r_n + 1'b1;
            end
            CMD_LK_END: begin
                if (op_ins && !r_ffound) begin
                    r_status <= ST_FULL;
                end
            end
            CMD_GROW: begin
                r_m <= {r_size[CW-2:0], 1'b0};
                r_i <= '0;
            end
            CMD_SHRINK: begin
                r_m <= r_size >> 1;
                r_i <= '0;
            end
            CMD_R_CLR: begin
                r_i <= o_status.clr_last ? '0 : r_i + 1'b1;
            end
            CMD_W_LIVE: begin
                r_k2 <= r_krd;
                r_v2 <= r_vrd;
                r_q  <= h1;
                r_x  <= h2;
                r_n  <= '0;
            end
            CMD_W_NEXT, CMD_P_PUT: begin
                r_i <= r_i + 1'b1;
            end
            CMD_P_NEXT: begin
                r_q <= (r_q + r_x) & m_mask;
                r_n <= r_n + 1'b1;
            end
            CMD_OUT: begin
                r_out.result_value <= r_val;
                r_out.hit          <= r_hit;
                r_out.status       <= r_status;
                r_out.entries_used <= live32[10:0];
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/dhte_ctrl.sv
// Controller: sequences lookups, inserts, removes, clears and bank rehashes.
`timescale 1ns / 1ps

module dhte_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  dhte_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output dhte_pkg::t_cmd       o_cmd
);
    import dhte_pkg::*;

    typedef enum logic [17:0] {
        S_RC0  = 18'b000000000000000001,
        S_RC1  = 18'b000000000000000010,
        S_IDLE = 18'b000000000000000100,
        S_DEC  = 18'b000000000000001000,
        S_C1   = 18'b000000000000010000,
        S_LKI  = 18'b000000000000100000,
        S_LKR  = 18'b000000000001000000,
        S_LKC  = 18'b000000000010000000,
        S_LKE  = 18'b000000000100000000,
        S_SHK  = 18'b000000001000000000,
        S_RCLR = 18'b000000010000000000,
        S_WRD  = 18'b000000100000000000,
        S_WCHK = 18'b000001000000000000,
        S_PRD  = 18'b000010000000000000,
        S_PCHK = 18'b000100000000000000,
        S_PFRC = 18'b001000000000000000,
        S_RFIN = 18'b010000000000000000,
        S_DONE = 18'b100000000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RC0;
        end else begin
            r_state <= n_state;
        end
    end

    // Choose the command and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_RC0: begin
                o_cmd   = CMD_CLR0;
                n_state = S_RC1;
            end
            S_RC1: begin
                o_cmd   = CMD_CLR1;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_status.bad_key) begin
                    o_cmd   = CMD_BAD;
                    n_state = S_DONE;
                end else if (i_status.op_ins) begin
                    if (i_status.grow_ok) begin
                        o_cmd   = CMD_GROW;
                        n_state = S_RCLR;
                    end else begin
                        n_state = S_LKI;
                    end
                end else if (i_status.op_rem || i_status.op_find) begin
                    n_state = S_LKI;
                end else if (i_status.op_clr) begin
                    o_cmd   = CMD_CLR0;
                    n_state = S_C1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_C1: begin
                o_cmd   = CMD_CLR1;
                n_state = S_DONE;
            end
            S_LKI: begin
                o_cmd   = CMD_LK_INIT;
                n_state = S_LKR;
            end
            S_LKR: begin
                o_cmd   = CMD_LK_RD;
                n_state = S_LKC;
            end
            S_LKC: begin
                if (i_status.key_match) begin
                    o_cmd   = CMD_HIT;
                    n_state = i_status.op_rem ? S_SHK : S_DONE;
                end else if (i_status.key_empty) begin
                    o_cmd   = CMD_MISS;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_LK_NEXT;
                    n_state = i_status.probe_last ? S_LKE : S_LKR;
                end
            end
            S_LKE: begin
                o_cmd   = CMD_LK_END;
                n_state = S_DONE;
            end
            S_SHK: begin
                if (i_status.shrink_ok) begin
                    o_cmd   = CMD_SHRINK;
                    n_state = S_RCLR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RCLR: begin
                o_cmd = CMD_R_CLR;
                if (i_status.clr_last) begin
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_cmd   = CMD_W_RD;
                n_state = S_WCHK;
            end
            S_WCHK: begin
                if (i_status.key_live) begin
                    o_cmd   = CMD_W_LIVE;
                    n_state = S_PRD;
                end else begin
                    o_cmd   = CMD_W_NEXT;
                    n_state = i_status.walk_last ? S_RFIN : S_WRD;
                end
            end
            S_PRD: begin
                o_cmd   = CMD_P_RD;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_status.key_empty) begin
                    o_cmd   = CMD_P_PUT;
                    n_state = i_status.walk_last ? S_RFIN : S_WRD;
                end else begin
                    o_cmd   = CMD_P_NEXT;
                    n_state = i_status.put_last ? S_PFRC : S_PRD;
                end
            end
            S_PFRC: begin
                o_cmd   = CMD_P_PUT;
                n_state = i_status.walk_last ? S_RFIN : S_WRD;
            end
            S_RFIN: begin
                o_cmd   = CMD_R_FIN;
                n_state = i_status.op_ins ? S_LKI : S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_RC0;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

FILE: rtl/double_hash_table_engine.sv
// Top level: double hashing key/value map engine.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_item  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall | o_out_item (t_out_item)
//
// One item at a time. After the accepting edge a lookup decodes the item and sets
// up the probe, then reads and checks one slot per probe, then loads the result
// into the output register and returns to idle for the next item. The single read
// port of the slot memories makes each probe a read followed by a check. A remove
// adds a shrink check and a search that runs out of probes adds an end step. A
// resize clears the new bank slot by slot, reads and checks each old slot, reads
// and checks each probe into the new bank and then switches banks.
// After reset a clearing pass empties the first two slots of bank 0.
// A result waiting in the output register under stall blocks only the end of
// the next item.
`timescale 1ns / 1ps

module double_hash_table_engine #(
    parameter int CAPACITY = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dhte_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dhte_pkg::t_out_item o_out_item
);
    import dhte_pkg::*;

    t_cmd       cmd;
    t_dp_status status;

    // Sequence the operations
    dhte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // Hold the tables and the result
    dhte_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
